// ===== hw/rtl/lzsd_pkg.sv =====
package lzsd_pkg;

    // Widest history address: the window must not exceed 2^24 bytes; the block itself does not enforce it.
    localparam int ADDR_MAX_W = 24;
    localparam int LEN_W      = 25;
    localparam int DIST_W     = 24;
    localparam int FIFO_DEPTH = 4;

    // Token decoding constants.
    localparam logic [7:0] EXT_TWO_BYTES  = 8'hfe;
    localparam logic [7:0] TOKEN_LONG_MIN = 8'd32;
    localparam logic [7:0] TOKEN_LONG_EXT = 8'd31;
    localparam logic [2:0] LIT_EXT_CODE   = 3'd7;
    localparam logic [3:0] MAT_EXT_CODE   = 4'd15;
    localparam logic [LEN_W-1:0] LIT_EXT_BASE  = 25'd7;
    localparam logic [LEN_W-1:0] MAT_EXT_BASE  = 25'd15;
    localparam logic [LEN_W-1:0] LONG_MAT_BASE = 25'd16;
    localparam logic [LEN_W-1:0] LONG_EXT_BASE = 25'd47;

    typedef enum logic [1:0] {
        FN_HEADER  = 2'd0,
        FN_LITERAL = 2'd1,
        FN_COPY    = 2'd2,
        FN_START   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_COPY    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DISTANCE = 2'd1,
        ERR_ORDER    = 2'd2
    } t_err;

    // One result as it sits in the output queue.
    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       out_byte;
        t_phase           expect_res;
        logic [LEN_W-1:0] pending;
        t_err             status;
    } t_result;

    // Decoded command handed from the front to the back.
    typedef struct packed {
        logic                  valid;
        logic                  is_copy;
        logic                  collide;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] waddr;
        t_result               res;
    } t_cmd;

    // History read request issued by the front.
    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
    } t_rd;

    // Base-254 variable length extension.
    function automatic logic [LEN_W-1:0] ext_len(input logic [31:0] raw);
        logic [7:0]  p;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [16:0] hi;
        logic [LEN_W-1:0] val;
        p  = raw[7:0];
        b1 = raw[15:8];
        b2 = raw[23:16];
        b3 = raw[31:24];
        if (p < EXT_TWO_BYTES) begin
            val = LEN_W'(p);
        end else if (p == EXT_TWO_BYTES) begin
            val = LEN_W'(17'(b2) * 17'd254 + 17'(b1));
        end else begin
            hi  = 17'(b3) * 17'd254 + 17'(b2);
            val = LEN_W'(hi) * 25'd254 + LEN_W'(b1);
        end
        return val;
    endfunction

endpackage

// ===== hw/rtl/lzsd_ram.sv =====
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lzsd_front.sv =====
module lzsd_front
    import lzsd_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_token,
    input  logic [31:0] i_lit_ext_raw,
    input  logic [31:0] i_match_ext_raw,
    input  logic [15:0] i_short_offset,
    input  logic [23:0] i_long_offset,
    input  logic [7:0]  i_literal_byte,
    output t_rd         o_rd,
    output t_cmd        o_cmd
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int PW = AW + 1;

    t_phase            r_phase, n_phase;
    logic              r_fault, n_fault;
    logic [31:0]       r_prod, n_prod;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_cp, n_cp;
    logic [DIST_W-1:0] r_lastd, n_lastd;
    logic [LEN_W-1:0]  r_lit, n_lit;
    logic [LEN_W-1:0]  r_mat, n_mat;
    t_cmd              r_cmd, n_cmd;

    logic              emit;
    logic              is_copy;
    logic              do_match;
    t_err              err;
    logic [LEN_W-1:0]  dec_lit;
    logic [LEN_W-1:0]  dec_mat;
    logic [31:0]       dist32;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_fault <= 1'b0;
            r_prod  <= '0;
            r_wp    <= '0;
            r_cp    <= '0;
            r_lastd <= '0;
            r_lit   <= '0;
            r_mat   <= '0;
            r_cmd   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fault <= n_fault;
            r_prod  <= n_prod;
            r_wp    <= n_wp;
            r_cp    <= n_cp;
            r_lastd <= n_lastd;
            r_lit   <= n_lit;
            r_mat   <= n_mat;
            r_cmd   <= n_cmd;
        end
    end

    // Decode the item and work out the next sequence state.
    always_comb begin
        n_phase  = r_phase;
        n_fault  = r_fault;
        n_prod   = r_prod;
        n_wp     = r_wp;
        n_cp     = r_cp;
        n_lastd  = r_lastd;
        n_lit    = r_lit;
        n_mat    = r_mat;
        emit     = 1'b0;
        is_copy  = 1'b0;
        do_match = 1'b0;
        err      = ERR_NONE;
        dec_lit  = '0;
        dec_mat  = '0;
        dist32   = '0;

        if (i_accept) begin
            if (r_fault) begin
                err = ERR_DISTANCE;
            end else begin
                unique case (t_func'(i_func))
                    FN_START: begin
                        n_lastd = '0;
                        n_lit   = '0;
                        n_mat   = '0;
                        n_phase = PH_HEADER;
                    end
                    FN_HEADER: begin
                        if (r_phase != PH_HEADER) begin
                            err = ERR_ORDER;
                        end else begin
                            if (i_token >= TOKEN_LONG_MIN) begin
                                dec_lit = LEN_W'(i_token[2:0]);
                                if (i_token[2:0] == LIT_EXT_CODE) begin
                                    dec_lit = ext_len(i_lit_ext_raw) + LIT_EXT_BASE;
                                end
                                dec_mat = LEN_W'(i_token[6:3]);
                                if (i_token[6:3] == MAT_EXT_CODE) begin
                                    dec_mat = ext_len(i_match_ext_raw) + MAT_EXT_BASE;
                                end
                                if (!i_token[7]) begin
                                    n_lastd = DIST_W'(i_short_offset);
                                end
                            end else if (i_token < TOKEN_LONG_EXT) begin
                                dec_mat = LEN_W'(i_token) + LONG_MAT_BASE;
                                n_lastd = i_long_offset;
                            end else begin
                                dec_mat = ext_len(i_match_ext_raw) + LONG_EXT_BASE;
                                n_lastd = i_long_offset;
                            end
                            n_lit = dec_lit;
                            n_mat = dec_mat;
                            if (dec_lit != '0) begin
                                n_phase = PH_LITERAL;
                            end else begin
                                do_match = 1'b1;
                            end
                        end
                    end
                    FN_LITERAL: begin
                        if (r_phase == PH_COPY) begin
                            err = ERR_ORDER;
                        end else begin
                            emit = 1'b1;
                            if (r_phase == PH_LITERAL) begin
                                n_lit = r_lit - 1'b1;
                                if (n_lit == '0) begin
                                    do_match = 1'b1;
                                end
                            end
                        end
                    end
                    FN_COPY: begin
                        if (r_phase != PH_COPY) begin
                            err = ERR_ORDER;
                        end else begin
                            emit    = 1'b1;
                            is_copy = 1'b1;
                            n_cp    = (r_cp == AW'(WINDOW_BYTES - 1)) ? '0 : r_cp + 1'b1;
                            n_mat   = r_mat - 1'b1;
                            if (n_mat == '0) begin
                                n_phase = PH_HEADER;
                            end
                        end
                    end
                    default: begin
                        err = ERR_ORDER;
                    end
                endcase

                // Every emitted byte advances the produced count and write pointer.
                if (emit) begin
                    n_prod = r_prod + 32'd1;
                    n_wp   = (r_wp == AW'(WINDOW_BYTES - 1)) ? '0 : r_wp + 1'b1;
                end

                // Literals done: check the distance and set up the copy.
                if (do_match) begin
                    dist32 = 32'(n_lastd);
                    if (n_lastd == '0 || dist32 > n_prod
                            || dist32 > 32'(WINDOW_BYTES)) begin
                        n_fault = 1'b1;
                        n_lit   = '0;
                        n_mat   = '0;
                        n_phase = PH_HEADER;
                        err     = ERR_DISTANCE;
                    end else begin
                        if (dist32 > 32'(n_wp)) begin
                            n_cp = AW'({1'b0, n_wp} + PW'(WINDOW_BYTES) - PW'(n_lastd));
                        end else begin
                            n_cp = AW'({1'b0, n_wp} - PW'(n_lastd));
                        end
                        n_phase = (n_mat != '0) ? PH_COPY : PH_HEADER;
                    end
                end
            end
        end

        // Build the command for the back.
        n_cmd                = '0;
        n_cmd.valid          = i_accept;
        n_cmd.is_copy        = is_copy;
        n_cmd.collide        = is_copy && r_cmd.valid && r_cmd.wr_en
                               && (r_cmd.waddr[AW-1:0] == r_cp);
        n_cmd.wr_en          = emit;
        n_cmd.waddr          = ADDR_MAX_W'(r_wp);
        n_cmd.res.byte_valid = emit;
        n_cmd.res.out_byte   = (emit && !is_copy) ? i_literal_byte : 8'd0;
        n_cmd.res.expect_res = n_phase;
        n_cmd.res.pending    = (n_phase == PH_LITERAL) ? n_lit
                             : (n_phase == PH_COPY) ? n_mat : '0;
        n_cmd.res.status     = err;
    end

    assign o_rd.en   = is_copy;
    assign o_rd.addr = ADDR_MAX_W'(r_cp);
    assign o_cmd     = r_cmd;

endmodule

// ===== hw/rtl/lzsd_back.sv =====
module lzsd_back
    import lzsd_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_rd     i_rd,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_res
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int QW = $clog2(FIFO_DEPTH);

    logic [7:0]  rdata;
    logic [7:0]  cur_byte;
    logic [7:0]  r_fwd;
    t_result     cur_res;
    t_result     r_q [FIFO_DEPTH];
    logic [QW-1:0] r_wr_ptr;
    logic [QW-1:0] r_rd_ptr;
    logic [QW:0]   r_count;
    logic          do_pop;

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (i_cmd.valid && i_cmd.wr_en),
        .i_waddr (i_cmd.waddr[AW-1:0]),
        .i_wdata (cur_byte),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr[AW-1:0]),
        .o_rdata (rdata)
    );

    // A copy reading the byte written in the same cycle takes the forwarded value.
    always_comb begin
        if (i_cmd.is_copy) begin
            cur_byte = i_cmd.collide ? r_fwd : rdata;
        end else begin
            cur_byte = i_cmd.res.out_byte;
        end
        cur_res          = i_cmd.res;
        cur_res.out_byte = cur_byte;
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= cur_byte;
    end

    // Output queue; space is held for the command in flight.
    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QW+1)'(i_cmd.valid) - (QW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_q[r_wr_ptr] <= cur_res;
        end
    end

    assign o_full  = ((QW+2)'(r_count) + (QW+2)'(i_cmd.valid)) >= (QW+2)'(FIFO_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_res   = r_q[r_rd_ptr];

endmodule

// ===== hw/rtl/lz_multistream_sequence_decoder_top.sv =====
// LZ sequence decoder with repeat offset. Headers, literal bytes, copy ticks and
// start-of-block items enter through a queue-style push port and every item yields
// exactly one result on the pop side, in order. One item is taken per clock cycle
// as long as the output queue has room; a result is registered in the front's
// command register and then written into the output queue before it shows on the
// pop side. The rate is set by the history memory, which does one read (for a copy
// tick) and one write (for each emitted byte) per cycle; a copy that reads the byte
// written one item earlier is served by forwarding. The history is not cleared after
// reset, so the block is ready at once.
module lz_multistream_sequence_decoder_top
    import lzsd_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_token,
    input  logic [31:0] i_lit_ext_raw,
    input  logic [31:0] i_match_ext_raw,
    input  logic [15:0] i_short_offset,
    input  logic [23:0] i_long_offset,
    input  logic [7:0]  i_literal_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_byte_valid,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_expect_res,
    output logic [24:0] o_pending,
    output logic [1:0]  o_status
);

    t_rd     rd;
    t_cmd    cmd;
    t_result res;
    logic    accept;

    assign accept = push && !full;

    // Front: decode and sequence control.
    lzsd_front #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_func          (i_func),
        .i_token         (i_token),
        .i_lit_ext_raw   (i_lit_ext_raw),
        .i_match_ext_raw (i_match_ext_raw),
        .i_short_offset  (i_short_offset),
        .i_long_offset   (i_long_offset),
        .i_literal_byte  (i_literal_byte),
        .o_rd            (rd),
        .o_cmd           (cmd)
    );

    // Back: history memory and output queue.
    lzsd_back #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_byte_valid = res.byte_valid;
    assign o_out_byte   = res.out_byte;
    assign o_expect_res = res.expect_res;
    assign o_pending    = res.pending;
    assign o_status     = res.status;

endmodule

// ===== hw/rtl/lzsd_checker.sv =====
module lzsd_assertions
    import lzsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_byte_valid,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_expect_res,
    input logic [24:0] o_pending
);

    // The queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("queue not empty after reset");

    // A waiting result that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_pending))
        else $error("waiting result changed");

    // A transaction without a byte carries a zero byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_out_byte == 8'd0)
        else $error("byte not zero without byte_valid");

    // Nothing is due while a header is expected.
    a_header_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_expect_res == PH_HEADER |-> o_pending == '0)
        else $error("pending count in header phase");

endmodule

bind lz_multistream_sequence_decoder_top lzsd_assertions u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_byte_valid (o_byte_valid),
    .o_out_byte   (o_out_byte),
    .o_expect_res (o_expect_res),
    .o_pending    (o_pending)
);

// ===== sim/lzsd_checker.sv =====
// Watches both queue ports of the sequence decoder, predicts one result per
// accepted item and compares every popped result with the oldest prediction.
module lzsd_checker
    import lzsd_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_token,
    input  logic [31:0] i_lit_ext_raw,
    input  logic [31:0] i_match_ext_raw,
    input  logic [15:0] i_short_offset,
    input  logic [23:0] i_long_offset,
    input  logic [7:0]  i_literal_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_out_byte,
    input  logic [1:0]  i_expect_res,
    input  logic [24:0] i_pending,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam logic [24:0] LEN_MASK = 25'h1ffffff;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        t_phase      expect_res;
        logic [24:0] pending;
        t_err        status;
    } t_decoded;

    // Shadow decoder state.
    logic [7:0]  hist [0:WINDOW_BYTES-1];
    logic [31:0] out_count;
    logic [23:0] dist_reg;
    logic [24:0] lits_due;
    logic [24:0] copies_due;
    logic [31:0] copy_rd;
    t_phase      cur_phase;
    logic        faulted;

    t_decoded    decoded_q[$];
    int          fail_count;

    assign o_fail_count  = fail_count;
    assign o_outstanding = decoded_q.size();

    // Base-254 length extension taken from its raw prefix and following bytes.
    function automatic logic [31:0] base254_len(input logic [31:0] raw);
        logic [31:0] acc;
        if (raw[7:0] < 8'hfe) begin
            acc = 32'(raw[7:0]);
        end else if (raw[7:0] == 8'hfe) begin
            acc = 32'(raw[23:16]) * 254 + 32'(raw[15:8]);
        end else begin
            acc = (32'(raw[31:24]) * 254 + 32'(raw[23:16])) * 254 + 32'(raw[15:8]);
        end
        return acc;
    endfunction

    task automatic store_byte(input logic [7:0] b);
        hist[out_count % WINDOW_BYTES] = b;
        out_count = out_count + 1;
    endtask

    // Literals are done: check the distance, then start copying or go idle.
    function automatic logic distance_bad();
        if (dist_reg == 0 || 32'(dist_reg) > out_count || 32'(dist_reg) > WINDOW_BYTES) begin
            faulted    = 1'b1;
            lits_due   = '0;
            copies_due = '0;
            cur_phase  = PH_HEADER;
            return 1'b1;
        end
        copy_rd   = (out_count - 32'(dist_reg)) % WINDOW_BYTES;
        cur_phase = (copies_due != 0) ? PH_COPY : PH_HEADER;
        return 1'b0;
    endfunction

    task automatic decode_item(output t_decoded r);
        logic [31:0] lit_len;
        logic [31:0] mat_len;
        t_func       fn;
        r  = '0;
        fn = t_func'(i_func);
        r.status = ERR_NONE;
        if (faulted) begin
            r.status = ERR_DISTANCE;
        end else if (fn == FN_START) begin
            dist_reg   = '0;
            lits_due   = '0;
            copies_due = '0;
            cur_phase  = PH_HEADER;
        end else if (fn == FN_HEADER) begin
            if (cur_phase != PH_HEADER) begin
                r.status = ERR_ORDER;
            end else begin
                lit_len = 0;
                if (i_token >= 8'd32) begin
                    lit_len = 32'(i_token[2:0]);
                    if (lit_len == 7) lit_len = base254_len(i_lit_ext_raw) + 7;
                    if (!i_token[7]) dist_reg = 24'(i_short_offset);
                    mat_len = 32'(i_token[6:3]);
                    if (mat_len == 15) mat_len = base254_len(i_match_ext_raw) + 15;
                end else if (i_token < 8'd31) begin
                    mat_len  = 32'(i_token) + 16;
                    dist_reg = i_long_offset;
                end else begin
                    mat_len  = base254_len(i_match_ext_raw) + 47;
                    dist_reg = i_long_offset;
                end
                lits_due   = 25'(lit_len) & LEN_MASK;
                copies_due = 25'(mat_len) & LEN_MASK;
                if (lits_due != 0) begin
                    cur_phase = PH_LITERAL;
                end else if (distance_bad()) begin
                    r.status = ERR_DISTANCE;
                end
            end
        end else if (fn == FN_LITERAL) begin
            if (cur_phase == PH_COPY) begin
                r.status = ERR_ORDER;
            end else begin
                r.byte_valid = 1'b1;
                r.out_byte   = i_literal_byte;
                store_byte(i_literal_byte);
                if (cur_phase == PH_LITERAL) begin
                    lits_due = lits_due - 25'd1;
                    if (lits_due == 0 && distance_bad()) r.status = ERR_DISTANCE;
                end
            end
        end else begin
            if (cur_phase != PH_COPY) begin
                r.status = ERR_ORDER;
            end else begin
                r.byte_valid = 1'b1;
                r.out_byte   = hist[copy_rd % WINDOW_BYTES];
                store_byte(r.out_byte);
                copy_rd    = (copy_rd + 1) % WINDOW_BYTES;
                copies_due = copies_due - 25'd1;
                if (copies_due == 0) cur_phase = PH_HEADER;
            end
        end
        r.expect_res = cur_phase;
        r.pending    = (cur_phase == PH_LITERAL) ? lits_due :
                       (cur_phase == PH_COPY) ? copies_due : '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    // Predict on every input transaction, compare on every output transaction.
    always @(posedge i_clk) begin
        t_decoded r;
        t_decoded want;
        if (!i_rst_n) begin
            out_count  <= '0;
            dist_reg   <= '0;
            lits_due   <= '0;
            copies_due <= '0;
            copy_rd    <= '0;
            cur_phase  <= PH_HEADER;
            faulted    <= 1'b0;
        end else begin
            if (i_push && !i_full) begin
                decode_item(r);
                decoded_q.push_back(r);
            end
            if (i_pop && !i_empty) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(i_out_byte), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", 32'(i_byte_valid), 32'(want.byte_valid));
                    if (i_out_byte !== want.out_byte)
                        report_mismatch("out_byte", 32'(i_out_byte), 32'(want.out_byte));
                    if (i_expect_res !== want.expect_res)
                        report_mismatch("expect_res", 32'(i_expect_res), 32'(want.expect_res));
                    if (i_pending !== want.pending)
                        report_mismatch("pending", 32'(i_pending), 32'(want.pending));
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import lzsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  func_drv;
    logic [7:0]  token_drv;
    logic [31:0] lit_ext_drv;
    logic [31:0] mat_ext_drv;
    logic [15:0] short_off_drv;
    logic [23:0] long_off_drv;
    logic [7:0]  lit_byte_drv;
    logic        empty;
    logic        pop;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [1:0]  expect_res;
    logic [24:0] pending;
    logic [1:0]  status;
    int          fail_count;
    int          outstanding;

    // Stimulus bookkeeping: items sent, bytes produced so far and the distance in force.
    int          items_sent;
    int          bytes_out;
    int          dist_now;
    logic        calm;
    int          pop_hold;
    int          quiet_cycles;

    lz_multistream_sequence_decoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (func_drv),
        .i_token        (token_drv),
        .i_lit_ext_raw  (lit_ext_drv),
        .i_match_ext_raw(mat_ext_drv),
        .i_short_offset (short_off_drv),
        .i_long_offset  (long_off_drv),
        .i_literal_byte (lit_byte_drv),
        .empty          (empty),
        .pop            (pop),
        .o_byte_valid   (byte_valid),
        .o_out_byte     (out_byte),
        .o_expect_res   (expect_res),
        .o_pending      (pending),
        .o_status       (status)
    );

    lzsd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_func         (func_drv),
        .i_token        (token_drv),
        .i_lit_ext_raw  (lit_ext_drv),
        .i_match_ext_raw(mat_ext_drv),
        .i_short_offset (short_off_drv),
        .i_long_offset  (long_off_drv),
        .i_literal_byte (lit_byte_drv),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_byte_valid   (byte_valid),
        .i_out_byte     (out_byte),
        .i_expect_res   (expect_res),
        .i_pending      (pending),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: pop with random stall bursts, always ready near the end.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            pop <= i_rst_n;
        end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 5);
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Push one item and hold it until the decoder takes it.
    task automatic send_item(input t_func fn, input logic [7:0] tok,
                             input logic [31:0] lext, input logic [31:0] mext,
                             input logic [15:0] soff, input logic [23:0] loff,
                             input logic [7:0] lb);
        push          <= 1'b1;
        func_drv      <= fn;
        token_drv     <= tok;
        lit_ext_drv   <= lext;
        mat_ext_drv   <= mext;
        short_off_drv <= soff;
        long_off_drv  <= loff;
        lit_byte_drv  <= lb;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_header(input logic [7:0] tok, input logic [31:0] lext,
                               input logic [31:0] mext, input logic [15:0] soff,
                               input logic [23:0] loff);
        send_item(FN_HEADER, tok, lext, mext, soff, loff, 8'($urandom));
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_item(FN_LITERAL, 8'($urandom), $urandom, $urandom, 16'($urandom),
                  24'($urandom), b);
    endtask

    task automatic send_tick();
        send_item(FN_COPY, 8'($urandom), $urandom, $urandom, 16'($urandom),
                  24'($urandom), 8'($urandom));
    endtask

    task automatic send_start();
        send_item(FN_START, 8'($urandom), $urandom, $urandom, 16'($urandom),
                  24'($urandom), 8'($urandom));
        dist_now = 0;
    endtask

    // Header with random fields, used where the decoder must refuse it.
    task automatic send_stray_header();
        send_header(8'($urandom), $urandom, $urandom, 16'($urandom), 24'($urandom));
    endtask

    // Extension field in one of the three encodings, kept to a short length.
    task automatic short_ext(output logic [31:0] raw, output int len);
        raw = $urandom;
        len = $urandom_range(0, 12);
        case ($urandom_range(0, 2))
            0: begin
                raw[7:0] = 8'(len);
            end
            1: begin
                raw[7:0]   = 8'hfe;
                raw[15:8]  = 8'(len);
                raw[23:16] = 8'h00;
            end
            default: begin
                raw[7:0]   = 8'hff;
                raw[15:8]  = 8'(len);
                raw[31:16] = 16'h0000;
            end
        endcase
    endtask

    // One well-formed sequence with random content and occasional stray items.
    task automatic send_sequence();
        logic [7:0]  tok;
        logic [31:0] lext;
        logic [31:0] mext;
        logic [15:0] soff;
        logic [23:0] loff;
        int          lit_len;
        int          mat_len;
        int          ext;
        int          reach;
        short_ext(lext, ext);
        short_ext(mext, mat_len);
        soff = 16'($urandom);
        loff = 24'($urandom);
        lit_len = 0;
        if (bytes_out > 0 && $urandom_range(0, 3) == 0) begin
            // Long form: no literals, distance from the 24-bit field.
            tok = 8'($urandom_range(0, 31));
            mat_len = (tok == 8'd31) ? mat_len + 47 : int'(tok) + 16;
            reach = (bytes_out > 65536) ? 65536 : bytes_out;
            loff = 24'($urandom_range(1, reach));
            dist_now = int'(loff);
        end else begin
            tok = 8'($urandom_range(32, 255));
            if (dist_now == 0) begin
                tok[7] = 1'b0;
                if (tok < 8'd32) tok[5] = 1'b1;
            end
            lit_len = (tok[2:0] == 3'd7) ? ext + 7 : int'(tok[2:0]);
            mat_len = (tok[6:3] == 4'd15) ? mat_len + 15 : int'(tok[6:3]);
            if (!tok[7]) begin
                reach = bytes_out + lit_len;
                if (reach > 65535) reach = 65535;
                if (reach == 0) begin
                    lit_len = 1;
                    tok[2:0] = 3'd1;
                    reach = 1;
                end
                soff = 16'($urandom_range(1, reach));
                dist_now = int'(soff);
            end
        end
        send_header(tok, lext, mext, soff, loff);
        for (int i = 0; i < lit_len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) != 0) send_stray_header();
                else send_tick();
            end
            send_literal(8'($urandom));
        end
        bytes_out += lit_len;
        for (int i = 0; i < mat_len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) != 0) send_stray_header();
                else send_literal(8'($urandom));
            end
            send_tick();
        end
        bytes_out += mat_len;
    endtask

    // Stop pushing and wait until every predicted result has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int seq_count;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        func_drv      = FN_START;
        token_drv     = '0;
        lit_ext_drv   = '0;
        mat_ext_drv   = '0;
        short_off_drv = '0;
        long_off_drv  = '0;
        lit_byte_drv  = '0;
        items_sent    = 0;
        bytes_out     = 0;
        dist_now      = 0;
        calm          = 1'b0;
        pop_hold      = 0;
        quiet_cycles  = 0;
        seq_count     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: ordering errors, trailing literals, overlapped copy.
        send_start();
        send_tick();
        send_literal(8'h00);
        send_literal(8'hff);
        send_literal(8'ha5);
        send_literal(8'h5a);
        bytes_out = 4;
        send_header(8'h39, $urandom, $urandom, 16'd4, 24'($urandom));
        send_stray_header();
        send_tick();
        send_literal(8'h3c);
        send_literal(8'h77);
        for (int i = 0; i < 7; i++) send_tick();
        bytes_out += 8;
        dist_now = 4;
        // Largest lengths, cut short by a start of block.
        send_header(8'h3f, 32'hffffffff, 32'hffffffff, 16'd1, 24'($urandom));
        send_literal(8'h81);
        send_start();
        send_header(8'd31, $urandom, 32'hffffffff, 16'($urandom), 24'd1);
        send_tick();
        send_start();
        bytes_out += 2;

        // Random part: mostly sequences, the rest loose items.
        while (items_sent < 750) begin
            if (items_sent > 600) calm = 1'b1;
            if (seq_count == 8) wait_drained();
            case ($urandom_range(0, 9))
                0: begin
                    send_literal(8'($urandom));
                    bytes_out++;
                end
                1: send_start();
                2: send_tick();
                default: begin
                    send_sequence();
                    seq_count++;
                end
            endcase
        end

        // Zero distance sets the sticky fault; everything after is refused.
        wait_drained();
        send_header(8'd0, $urandom, $urandom, 16'($urandom), 24'd0);
        send_literal(8'h11);
        send_start();
        send_tick();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== lz_multistream_sequence_decoder_top.f =====
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_ram.sv
hw/rtl/lzsd_front.sv
hw/rtl/lzsd_back.sv
hw/rtl/lz_multistream_sequence_decoder_top.sv
hw/rtl/lzsd_checker.sv
sim/lzsd_checker.sv
sim/tb_top.sv
